// ===== rtl/phsp_pkg.sv =====
// Package: types and codes shared by the packet header stream parser.
`timescale 1ns / 1ps

package phsp_pkg;

	typedef enum logic [2:0] {
		PH_TAG   = 3'd0,
		PH_MULTI = 3'd1,
		PH_NEW1  = 3'd2,
		PH_NEW2  = 3'd3,
		PH_SKIP  = 3'd4,
		PH_HALT  = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NOTTAG  = 3'd1,
		ST_INDEF   = 3'd2,
		ST_ILLEGAL = 3'd3,
		ST_TOOLONG = 3'd4,
		ST_TRUNC   = 3'd5
	} status_t;

	localparam logic [7:0] TAG_MARK      = 8'h80;
	localparam logic [7:0] FORMAT_MASK   = 8'hc0;
	localparam logic [7:0] OLD_TAG_MASK  = 8'h3c;
	localparam logic [7:0] LEN_TYPE_MASK = 8'h03;
	localparam logic [7:0] NEW_TAG_MASK  = 8'h3f;
	localparam logic [7:0] TWO_OCTET_MIN = 8'd192;
	localparam logic [7:0] PARTIAL_MIN   = 8'd224;
	localparam logic [7:0] FIVE_OCTET    = 8'd255;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  packet_tag;
		logic        new_format;
		logic [31:0] body_offset;
		logic [31:0] body_length;
		logic [2:0]  status;
	} out_item_t;

	typedef struct packed {
		phase_t      phase;
		logic [31:0] byte_offset;
		logic [2:0]  length_bytes_left;
		logic [31:0] length_accumulator;
		logic [5:0]  held_tag;
		logic        held_format;
		logic [31:0] skip_left;
	} state_t;

	typedef struct packed {
		logic      valid;
		out_item_t item;
	} result_t;

endpackage

// ===== rtl/phsp_step.sv =====
// Per-byte header parse: next parser state and the optional result.
`timescale 1ns / 1ps

module phsp_step (
	input  phsp_pkg::state_t   cur,
	input  logic [31:0]        seq_len,
	input  phsp_pkg::in_item_t item,
	output phsp_pkg::state_t   nxt,
	output phsp_pkg::result_t  res
);

	always_comb begin
		logic [31:0] o;
		logic [32:0] o_inc;
		logic [32:0] end_sum;
		logic        last;
		logic        do_finish;
		logic        do_fail;
		phsp_pkg::status_t fail_code;
		logic [7:0]  b;

		b = item.data_byte;
		nxt = cur;
		if (item.restart) begin
			nxt.byte_offset        = '0;
			nxt.phase              = phsp_pkg::PH_TAG;
			nxt.length_bytes_left  = '0;
			nxt.length_accumulator = '0;
			nxt.skip_left          = '0;
		end
		o = nxt.byte_offset;
		if (o != 32'hffff_ffff)
			nxt.byte_offset = o + 32'd1;

		o_inc     = {1'b0, o} + 33'd1;
		last      = (o_inc >= {1'b0, seq_len});
		do_finish = 1'b0;
		do_fail   = 1'b0;
		fail_code = phsp_pkg::ST_TRUNC;

		if (nxt.phase == phsp_pkg::PH_HALT) begin
			// halted: ignore until restart
		end else if (nxt.phase == phsp_pkg::PH_SKIP) begin
			if (nxt.skip_left != '0)
				nxt.skip_left = nxt.skip_left - 32'd1;
			if (nxt.skip_left == '0)
				nxt.phase = phsp_pkg::PH_TAG;
		end else if ({1'b0, o} >= {1'b0, seq_len}) begin
			// past the end: fine between packets, a truncation inside a header
			if (nxt.phase != phsp_pkg::PH_TAG)
				do_fail = 1'b1;
		end else begin
			unique case (nxt.phase)
				phsp_pkg::PH_TAG: begin
					nxt.held_tag           = '0;
					nxt.held_format        = 1'b0;
					nxt.length_accumulator = '0;
					if ((b & phsp_pkg::TAG_MARK) != phsp_pkg::TAG_MARK) begin
						do_fail   = 1'b1;
						fail_code = phsp_pkg::ST_NOTTAG;
					end else if ((b & phsp_pkg::FORMAT_MASK) == phsp_pkg::TAG_MARK) begin
						nxt.held_tag    = 6'(((b & phsp_pkg::OLD_TAG_MASK) >> 2));
						nxt.held_format = 1'b0;
						if ((b & phsp_pkg::LEN_TYPE_MASK) == phsp_pkg::LEN_TYPE_MASK) begin
							do_fail   = 1'b1;
							fail_code = phsp_pkg::ST_INDEF;
						end else begin
							nxt.length_bytes_left = 3'(3'd1 << b[1:0]);
							nxt.phase             = phsp_pkg::PH_MULTI;
							do_fail               = last;
						end
					end else begin
						nxt.held_tag    = 6'(b & phsp_pkg::NEW_TAG_MASK);
						nxt.held_format = 1'b1;
						nxt.phase       = phsp_pkg::PH_NEW1;
						do_fail         = last;
					end
				end
				phsp_pkg::PH_MULTI: begin
					nxt.length_accumulator = {nxt.length_accumulator[23:0], b};
					if (nxt.length_bytes_left != '0)
						nxt.length_bytes_left = nxt.length_bytes_left - 3'd1;
					if (nxt.length_bytes_left == '0)
						do_finish = 1'b1;
					else
						do_fail = last;
				end
				phsp_pkg::PH_NEW1: begin
					if (b < phsp_pkg::TWO_OCTET_MIN) begin
						nxt.length_accumulator = {24'd0, b};
						do_finish              = 1'b1;
					end else if (b < phsp_pkg::PARTIAL_MIN) begin
						nxt.length_accumulator = {19'd0, 5'(b - phsp_pkg::TWO_OCTET_MIN), 8'd0};
						nxt.phase              = phsp_pkg::PH_NEW2;
						do_fail                = last;
					end else if (b == phsp_pkg::FIVE_OCTET) begin
						nxt.length_accumulator = '0;
						nxt.length_bytes_left  = 3'd4;
						nxt.phase              = phsp_pkg::PH_MULTI;
						do_fail                = last;
					end else begin
						do_fail   = 1'b1;
						fail_code = phsp_pkg::ST_ILLEGAL;
					end
				end
				phsp_pkg::PH_NEW2: begin
					nxt.length_accumulator = nxt.length_accumulator + {24'd0, b}
						+ {24'd0, phsp_pkg::TWO_OCTET_MIN};
					do_finish = 1'b1;
				end
				default: begin
					nxt.phase = phsp_pkg::PH_HALT;
				end
			endcase
		end

		// body must end inside the sequence, sum taken without wrap
		end_sum = o_inc + {1'b0, nxt.length_accumulator};
		if (do_finish && end_sum > {1'b0, seq_len}) begin
			do_finish = 1'b0;
			do_fail   = 1'b1;
			fail_code = phsp_pkg::ST_TOOLONG;
		end

		res.valid            = do_finish || do_fail;
		res.item.packet_tag  = nxt.held_tag;
		res.item.new_format  = nxt.held_format;
		res.item.body_offset = '0;
		res.item.body_length = '0;
		res.item.status      = phsp_pkg::ST_OK;
		if (do_fail) begin
			res.item.status = fail_code;
			nxt.phase       = phsp_pkg::PH_HALT;
		end else if (do_finish) begin
			res.item.body_offset = o_inc[31:0];
			res.item.body_length = nxt.length_accumulator;
			nxt.skip_left        = nxt.length_accumulator;
			nxt.phase = (nxt.length_accumulator == '0) ? phsp_pkg::PH_TAG : phsp_pkg::PH_SKIP;
		end
	end

endmodule

// ===== rtl/packet_header_stream_parser.sv =====
// Top level: packet header stream parser with input and result registers.
`timescale 1ns / 1ps

// Binary packet header parser. One byte request per cycle is taken on the
// in channel; each byte passes an input register, then the per-byte header
// logic updates the parser state and loads the result register, which drives
// the out channel. A new byte is accepted every cycle while the out side keeps
// up (the result register frees as it is taken). A header yields one result on
// the byte that completes it or that fails it; body bytes are skipped with no
// result. After an error result the parser halts until a byte with restart
// set. The sequence length register (cfg channel, always ready) should be
// written while no byte is in flight.

module packet_header_stream_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  phsp_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output phsp_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [31:0]         cfg_data
);

	logic                valid_s1;
	phsp_pkg::in_item_t  item_s1;
	phsp_pkg::state_t    state_q;
	phsp_pkg::state_t    state_nxt;
	phsp_pkg::result_t   res;
	logic                out_valid_q;
	phsp_pkg::out_item_t out_q;
	logic [31:0]         seq_len_q;
	logic                advance;

	phsp_step u_step (
		.cur     (state_q),
		.seq_len (seq_len_q),
		.item    (item_s1),
		.nxt     (state_nxt),
		.res     (res)
	);

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1                   <= 1'b0;
			out_valid_q                <= 1'b0;
			seq_len_q                  <= '0;
			state_q.phase              <= phsp_pkg::PH_TAG;
			state_q.byte_offset        <= '0;
			state_q.length_bytes_left  <= '0;
			state_q.length_accumulator <= '0;
			state_q.held_tag           <= '0;
			state_q.held_format        <= 1'b0;
			state_q.skip_left          <= '0;
		end else begin
			if (cfg_valid)
				seq_len_q <= cfg_data;
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance) begin
				state_q     <= state_nxt;
				out_valid_q <= res.valid;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_data;
		if (advance && res.valid)
			out_q <= res.item;
	end

	// an error result leaves the parser halted
	a_err_halts: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.valid && res.item.status != phsp_pkg::ST_OK
		|=> state_q.phase == phsp_pkg::PH_HALT)
		else $error("parser not halted after error result");

	// a body skip always has bytes left to skip
	a_skip_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == phsp_pkg::PH_SKIP |-> state_q.skip_left != '0)
		else $error("skip phase with zero bytes left");

	// multi-byte length phase always has length bytes pending, at most four
	a_len_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == phsp_pkg::PH_MULTI
		|-> state_q.length_bytes_left != '0 && state_q.length_bytes_left <= 3'd4)
		else $error("bad length byte count");

	// with the result register empty the input side never stalls
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty result register");

endmodule

// ===== sim/tb_packet_header_stream_parser.sv =====
// Testbench: byte stream driver, header predictor and result checker for the parser.
`timescale 1ns / 1ps

module tb_packet_header_stream_parser;
	import phsp_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;

	packet_header_stream_parser DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// predicted parser state
	phase_t      hdr_phase;
	logic [31:0] hdr_offset;
	logic [2:0]  hdr_left;
	logic [31:0] hdr_acc;
	logic [5:0]  hdr_tag;
	logic        hdr_format;
	logic [31:0] hdr_skip;
	logic [31:0] hdr_seq_len;

	in_item_t    pending_bytes[$];
	out_item_t   expected_headers[$];
	int          gen_count = 0;
	int          mismatch_count = 0;
	int unsigned idle_pct = 33;
	logic        in_taken = 1'b0;

	logic [31:0] plan_len [10] = '{32'hffff_ffff, 60, 1, 2, 25, 500, 0, 8, 32'hffff_ffff, 40};
	int          plan_items [10] = '{150, 200, 60, 80, 150, 200, 30, 100, 150, 200};
	int          plan_idle [10] = '{33, 33, 33, 33, 0, 33, 33, 33, 33, 33};

	always #1 clk = ~clk;

	function automatic void report_header(input logic [31:0] bofs, input logic [31:0] blen,
			input status_t st);
		out_item_t res;
		res.packet_tag  = hdr_tag;
		res.new_format  = hdr_format;
		res.body_offset = bofs;
		res.body_length = blen;
		res.status      = st;
		expected_headers.push_back(res);
		if (st != ST_OK)
			hdr_phase = PH_HALT;
	endfunction

	function automatic void close_header(input logic [31:0] o);
		logic [31:0] bofs;
		bofs = o + 32'd1;
		if ({1'b0, bofs} + {1'b0, hdr_acc} > {1'b0, hdr_seq_len}) begin
			report_header('0, '0, ST_TOOLONG);
			return;
		end
		hdr_skip = hdr_acc;
		if (hdr_acc == 0)
			hdr_phase = PH_TAG;
		else
			hdr_phase = PH_SKIP;
		report_header(bofs, hdr_acc, ST_OK);
	endfunction

	function automatic logic at_last(input logic [31:0] o);
		return {1'b0, o} + 33'd1 >= {1'b0, hdr_seq_len};
	endfunction

	function automatic void parse_byte(input in_item_t it);
		logic [7:0]  b;
		logic [7:0]  field;
		logic [31:0] o;
		b = it.data_byte;
		if (it.restart) begin
			hdr_offset = '0;
			hdr_phase  = PH_TAG;
			hdr_left   = '0;
			hdr_acc    = '0;
			hdr_skip   = '0;
		end
		o = hdr_offset;
		if (hdr_offset != 32'hffff_ffff)
			hdr_offset = hdr_offset + 32'd1;
		if (hdr_phase == PH_HALT)
			return;
		if (hdr_phase == PH_SKIP) begin
			if (hdr_skip != 0)
				hdr_skip = hdr_skip - 32'd1;
			if (hdr_skip == 0)
				hdr_phase = PH_TAG;
			return;
		end
		// past the end: ignored between packets, truncation inside a header
		if (o >= hdr_seq_len) begin
			if (hdr_phase != PH_TAG)
				report_header('0, '0, ST_TRUNC);
			return;
		end
		case (hdr_phase)
			PH_TAG: begin
				hdr_tag    = '0;
				hdr_format = 1'b0;
				hdr_acc    = '0;
				if ((b & TAG_MARK) != TAG_MARK) begin
					report_header('0, '0, ST_NOTTAG);
					return;
				end
				if ((b & FORMAT_MASK) == TAG_MARK) begin
					field      = (b & OLD_TAG_MASK) >> 2;
					hdr_tag    = field[5:0];
					hdr_format = 1'b0;
					field      = b & LEN_TYPE_MASK;
					if (field == LEN_TYPE_MASK) begin
						report_header('0, '0, ST_INDEF);
						return;
					end
					hdr_left  = 3'd1 << field[1:0];
					hdr_phase = PH_MULTI;
				end else begin
					field      = b & NEW_TAG_MASK;
					hdr_tag    = field[5:0];
					hdr_format = 1'b1;
					hdr_phase  = PH_NEW1;
				end
				if (at_last(o))
					report_header('0, '0, ST_TRUNC);
			end
			PH_MULTI: begin
				hdr_acc = (hdr_acc << 8) | {24'd0, b};
				if (hdr_left != 0)
					hdr_left = hdr_left - 3'd1;
				if (hdr_left == 0)
					close_header(o);
				else if (at_last(o))
					report_header('0, '0, ST_TRUNC);
			end
			PH_NEW1: begin
				if (b < TWO_OCTET_MIN) begin
					hdr_acc = {24'd0, b};
					close_header(o);
					return;
				end
				if (b < PARTIAL_MIN) begin
					hdr_acc   = {24'd0, b - TWO_OCTET_MIN} << 8;
					hdr_phase = PH_NEW2;
				end else if (b == FIVE_OCTET) begin
					hdr_acc   = '0;
					hdr_left  = 3'd4;
					hdr_phase = PH_MULTI;
				end else begin
					report_header('0, '0, ST_ILLEGAL);
					return;
				end
				if (at_last(o))
					report_header('0, '0, ST_TRUNC);
			end
			PH_NEW2: begin
				hdr_acc = hdr_acc + {24'd0, b} + {24'd0, TWO_OCTET_MIN};
				close_header(o);
			end
			default: hdr_phase = PH_HALT;
		endcase
	endfunction

	function automatic void push_byte(input logic [7:0] b, input logic r);
		in_item_t it;
		it.data_byte = b;
		it.restart   = r;
		pending_bytes.push_back(it);
		gen_count++;
	endfunction

	// mostly short lengths, some all-ones and wide values
	function automatic logic [31:0] pick_length(input int bits);
		logic [31:0] mask;
		logic [31:0] val;
		int          sel;
		mask = (bits >= 32) ? 32'hffff_ffff : ((32'd1 << bits) - 32'd1);
		sel  = $urandom_range(99);
		if (sel < 80)
			val = $urandom_range(12);
		else if (sel < 90)
			val = 32'hffff_ffff;
		else
			val = $urandom;
		return val & mask;
	endfunction

	function automatic void push_packet(input logic first_restart);
		logic [31:0] rnd;
		logic [31:0] blen;
		logic [7:0]  lead;
		int          sel;
		int          len_type;
		int          nbody;
		rnd = $urandom;
		sel = $urandom_range(99);
		if (sel < 6) begin
			push_byte(rnd[7:0], rnd[8] | first_restart);
			return;
		end
		if (sel < 45) begin
			len_type = ($urandom_range(19) == 0) ? 3 : $urandom_range(2);
			push_byte({2'b10, rnd[3:0], len_type[1:0]}, first_restart);
			if (len_type == 3)
				return;
			blen = pick_length(8 << len_type);
			for (int i = (1 << len_type) - 1; i >= 0; i--)
				push_byte(blen[i*8 +: 8], 1'b0);
		end else begin
			push_byte({2'b11, rnd[5:0]}, first_restart);
			sel = $urandom_range(99);
			if (sel < 70) begin
				blen = ($urandom_range(9) == 0) ? $urandom_range(191) : $urandom_range(12);
				push_byte(blen[7:0], 1'b0);
			end else if (sel < 76) begin
				lead = ($urandom_range(3) == 0) ? 8'($urandom_range(223, 192)) : TWO_OCTET_MIN;
				push_byte(lead, 1'b0);
				push_byte(rnd[15:8], 1'b0);
				blen = ({24'd0, lead} - 32'd192) * 32'd256 + {24'd0, rnd[15:8]} + 32'd192;
			end else if (sel < 94) begin
				push_byte(FIVE_OCTET, 1'b0);
				blen = pick_length(32);
				for (int i = 3; i >= 0; i--)
					push_byte(blen[i*8 +: 8], 1'b0);
			end else begin
				push_byte(8'($urandom_range(254, 224)), 1'b0);
				return;
			end
		end
		// very long bodies get a token tail; a later restart cuts the skip short
		nbody = (blen > 260) ? 2 : int'(blen);
		for (int i = 0; i < nbody; i++) begin
			rnd = $urandom;
			push_byte(rnd[7:0], rnd[15:10] == 0);
		end
	endfunction

	function automatic void push_sequence();
		int n;
		n = $urandom_range(8, 1);
		for (int k = 0; k < n; k++)
			push_packet((k == 0) ? 1'b1 : ($urandom_range(29) == 0));
	endfunction

	task automatic wait_idle();
		while (pending_bytes.size() != 0 || in_valid || expected_headers.size() != 0)
			@(negedge clk);
		// skipped bytes give no result, so let the pipeline empty
		repeat (6) @(negedge clk);
	endtask

	task automatic write_seq_len(input logic [31:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		hdr_seq_len = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// request driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				in_taken = 1'b0;
				if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
					in_valid <= 1'b1;
					in_data  <= pending_bytes[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= idle_pct);
	end

	// monitor: check results, predict accepted bytes
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_headers.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: tag=%0d new=%0d ofs=%0d len=%0d st=%0d",
						out_data.packet_tag, out_data.new_format, out_data.body_offset,
						out_data.body_length, out_data.status);
			end else begin
				want = expected_headers.pop_front();
				if (out_data.packet_tag !== want.packet_tag ||
						out_data.new_format !== want.new_format ||
						out_data.body_offset !== want.body_offset ||
						out_data.body_length !== want.body_length ||
						out_data.status !== want.status) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"mismatch: exp tag=%0d new=%0d ofs=%0d len=%0d st=%0d",
							" got tag=%0d new=%0d ofs=%0d len=%0d st=%0d"},
							want.packet_tag, want.new_format, want.body_offset,
							want.body_length, want.status, out_data.packet_tag,
							out_data.new_format, out_data.body_offset,
							out_data.body_length, out_data.status);
				end
			end
		end
		if (arst_n && in_valid && in_ready) begin
			parse_byte(in_data);
			void'(pending_bytes.pop_front());
			in_taken = 1'b1;
		end
	end

	initial begin
		#400000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int target;
		clk         = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		out_ready   = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		hdr_phase   = PH_TAG;
		hdr_offset  = '0;
		hdr_left    = '0;
		hdr_acc     = '0;
		hdr_tag     = '0;
		hdr_format  = 1'b0;
		hdr_skip    = '0;
		hdr_seq_len = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// zero-length sequence after reset: everything ignored
		push_byte(8'hc5, 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte(8'h80, 1'b0);
		wait_idle();

		write_seq_len(100);
		push_byte(8'hbc, 1'b1);   // old, tag 15, one length byte
		push_byte(8'h01, 1'b0);
		push_byte(8'h5a, 1'b0);
		push_byte(8'h85, 1'b0);   // old, two length bytes, empty body
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hff, 1'b0);   // new, tag 63, empty body
		push_byte(8'h00, 1'b0);
		push_byte(8'hc0, 1'b0);   // new, five-octet length
		push_byte(FIVE_OCTET, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h02, 1'b0);
		push_byte(8'hff, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hc2, 1'b0);   // two-octet length, runs past the end
		push_byte(8'hc0, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);   // halted
		push_byte(8'h7f, 1'b1);   // not a tag
		push_byte(8'h83, 1'b1);   // indefinite length
		push_byte(8'hc1, 1'b1);   // partial length
		push_byte(8'he0, 1'b0);
		push_byte(8'h8a, 1'b1);   // four length bytes, all ones
		push_byte(8'hff, 1'b0);
		push_byte(8'hff, 1'b0);
		push_byte(8'hff, 1'b0);
		push_byte(8'hff, 1'b0);
		wait_idle();

		// header cut off by the end of the sequence, then a body running past it
		write_seq_len(2);
		push_byte(8'hc3, 1'b1);
		push_byte(8'hff, 1'b0);
		push_byte(8'hf0, 1'b1);
		push_byte(8'h05, 1'b0);
		wait_idle();

		// length lowered in the middle of a header
		write_seq_len(100);
		push_byte(8'h88, 1'b1);
		wait_idle();
		write_seq_len(1);
		push_byte(8'h10, 1'b0);
		wait_idle();

		for (int p = 0; p < 10; p++) begin
			write_seq_len(plan_len[p]);
			idle_pct = plan_idle[p];
			target   = gen_count + plan_items[p];
			while (gen_count < target)
				push_sequence();
			wait_idle();
		end

		repeat (10) @(negedge clk);
		if (mismatch_count == 0 && expected_headers.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/phsp_pkg.sv
rtl/phsp_step.sv
rtl/packet_header_stream_parser.sv
sim/tb_packet_header_stream_parser.sv
